FILE: hdl/fcv_pkg.sv
// ============================================================================
// fcv_pkg
// Types, constants and widths shared by the cross variation pipeline.
// ============================================================================
`default_nettype none
package fcv_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int CSR_IDX_W     = 2;
   localparam int PIPE_DEPTH    = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMOUNT  = 2'd0,
      CSR_EPSILON = 2'd1,
      CSR_KEEP_Z  = 2'd2
   } csr_idx_type;

   localparam logic [31:0] AMOUNT_RST  = 32'd65536;
   localparam logic [31:0] EPSILON_RST = 32'd4295;
   localparam logic        KEEP_Z_RST  = 1'b1;

   typedef struct packed {
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               clipped;
   } rsp_type;
endpackage
`default_nettype wire

FILE: hdl/fcv_stream_if.sv
// ============================================================================
// fcv_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ============================================================================
`default_nettype none
interface fcv_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/flame_cross_variation.sv
// ============================================================================
// flame_cross_variation
// Cross variation of the fractal flame iteration in signed fixed point.
// ============================================================================
//  channel | dir | payload                                  | handshake
//  req_    | in  | in_x in_y in_z acc_x acc_y acc_z         | valid/ready
//  rsp_    | out | out_x out_y out_z clipped                | valid/ready
//  csr_    | in  | amount epsilon keep_z                    | write enable
//
//  One item per cycle unless the output stalls. The path from input transfer
//  to result valid: four stages of squares and products, sixteen square root
//  stages of four bits, one divide setup stage, nine divide stages of four bits
//  and the final sum stage. Reset clears the valid bits and loads the register
//  reset values. A stall at the output freezes all stages; nothing is lost.
// ============================================================================
`default_nettype none
module flame_cross_variation
   import fcv_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   fcv_stream_if.sink                req,
   fcv_stream_if.source              rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_idx,
   input  wire logic [WORD_W-1:0]    csr_wdata
);
   localparam int SQ_STAGES = 16;        // 64 root bits, 4 per stage
   localparam int SQ_BITS   = 4;
   localparam int QW        = 36;        // quotient window, 4 bits per stage
   localparam int DV_STAGES = 9;
   localparam int DV_BITS   = 4;
   localparam int NW        = 64 + FRAC_BITS + 1;
   localparam int N         = SQ_STAGES + DV_STAGES + 6;
   localparam logic [QW-1:0] CAP = QW'(64'h2_0000_0000);

   logic signed [31:0] amount_ff;
   logic        [31:0] epsilon_ff;
   logic               keep_z_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff  <= AMOUNT_RST;
         epsilon_ff <= EPSILON_RST;
         keep_z_ff  <= KEEP_Z_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_AMOUNT:  amount_ff  <= csr_wdata;
            CSR_EPSILON: epsilon_ff <= csr_wdata;
            CSR_KEEP_Z:  keep_z_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline control: a stall freezes every stage
   logic [N-1:0] vld_ff;
   logic         adv;
   assign adv       = !vld_ff[N-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[N-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[N-2:0], req.valid};
   end

   // side data carried along the pipe
   typedef struct packed {
      logic signed [63:0] nx;
      logic signed [63:0] ny;
      logic signed [63:0] tz;
      logic               kz;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
   } side_type;

   // stage 0: squares and products (tz holds the raw z product here)
   side_type      s0_ff;
   logic [63:0]   xx_ff, yy_ff;
   logic signed [63:0] x64, y64, z64, a64;

   assign x64 = 64'(req.data.in_x);
   assign y64 = 64'(req.data.in_y);
   assign z64 = 64'(req.data.in_z);
   assign a64 = 64'(amount_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff    <= 64'(x64 * x64);
         yy_ff    <= 64'(y64 * y64);
         s0_ff.nx <= x64 * a64;
         s0_ff.ny <= y64 * a64;
         s0_ff.tz <= z64 * a64;
         s0_ff.kz <= keep_z_ff;
         s0_ff.ax <= req.data.acc_x;
         s0_ff.ay <= req.data.acc_y;
         s0_ff.az <= req.data.acc_z;
      end
   end

   // stage 1: |x*x - y*y| and the rounded z term
   logic [63:0] sabs_ff;
   logic [63:0] pzm, pzr;
   side_type    s1_in, s1_ff;
   assign pzm = s0_ff.tz[63] ? 64'(-s0_ff.tz) : 64'(s0_ff.tz);
   assign pzr = (pzm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

   always_comb begin
      s1_in    = s0_ff;
      s1_in.tz = s0_ff.tz[63] ? $signed(64'd0 - pzr) : $signed(pzr);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sabs_ff <= (xx_ff > yy_ff) ? xx_ff - yy_ff : yy_ff - xx_ff;
         s1_ff   <= s1_in;
      end
   end

   // stage 2: partial products of S squared
   logic [31:0] s_hi, s_lo;
   logic [63:0] pp_hh_ff, pp_hl_ff, pp_ll_ff;
   side_type    s2_ff;
   assign s_hi = sabs_ff[63:32];
   assign s_lo = sabs_ff[31:0];
   always_ff @(posedge clock) begin
      if (adv) begin
         pp_hh_ff <= 64'(s_hi) * 64'(s_hi);
         pp_hl_ff <= 64'(s_hi) * 64'(s_lo);
         pp_ll_ff <= 64'(s_lo) * 64'(s_lo);
         s2_ff    <= s1_ff;
      end
   end

   // stage 3: S squared plus scaled epsilon
   logic [127:0] dsq_ff;
   side_type     s3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dsq_ff <= (128'(pp_hh_ff) << 64) + (128'(pp_hl_ff) << 33) + 128'(pp_ll_ff)
                   + (128'(epsilon_ff) << (4 * FRAC_BITS - 32));
         s3_ff  <= s2_ff;
      end
   end

   // square root stages
   logic [127:0] rad [SQ_STAGES+1];
   logic [63:0]  rt  [SQ_STAGES+1];
   logic [129:0] rm  [SQ_STAGES+1];
   side_type     sq_side_ff [SQ_STAGES];
   assign rad[0] = dsq_ff;
   assign rt[0]  = '0;
   assign rm[0]  = '0;
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      fcv_sqrt_stage #(.RW(64), .BITS(SQ_BITS)) u_sq (
         .clock(clock), .en(adv),
         .rad_in(rad[g]), .root_in(rt[g]), .rem_in(rm[g]),
         .rad_out(rad[g+1]), .root_out(rt[g+1]), .rem_out(rm[g+1]));
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_side_ff[g] <= (g == 0) ? s3_ff : sq_side_ff[(g == 0) ? 0 : g-1];
         end
      end
   end

   // divide setup: num = (|n| << F+1) + d, den = 2d
   logic [63:0] dd;
   logic [64:0] den;
   logic [63:0] mx, my;
   side_type    sl;
   assign sl  = sq_side_ff[SQ_STAGES-1];
   assign dd  = (rt[SQ_STAGES] == '0) ? 64'd1 : rt[SQ_STAGES];
   assign den = {dd, 1'b0};
   assign mx  = sl.nx[63] ? 64'(-sl.nx) : sl.nx;
   assign my  = sl.ny[63] ? 64'(-sl.ny) : sl.ny;

   // long division with early cap: quotient bits above QW only flag overflow
   typedef struct packed {
      logic [NW:0]   numx;
      logic [NW:0]   numy;
      logic [64:0]   den;
      logic [65:0]   remx;
      logic [65:0]   remy;
      logic [QW-1:0] qx;
      logic [QW-1:0] qy;
      logic          ovx;
      logic          ovy;
   } div_type;

   div_type dv_ff [DV_STAGES+1];
   side_type dv_side_ff [DV_STAGES+1];
   div_type d0;
   logic [NW:0] nxw, nyw;
   logic [65:0] hx, hy;

   // high part: bits above the quotient window resolved in one compare
   assign nxw = ((NW+1)'(mx) << (FRAC_BITS + 1)) + (NW+1)'(dd);
   assign nyw = ((NW+1)'(my) << (FRAC_BITS + 1)) + (NW+1)'(dd);
   assign hx  = 66'(nxw >> QW);
   assign hy  = 66'(nyw >> QW);
   always_comb begin
      d0 = '0;
      d0.den  = den;
      d0.numx = nxw;
      d0.numy = nyw;
      d0.ovx  = (hx >= 66'(den));
      d0.ovy  = (hy >= 66'(den));
      d0.remx = hx;
      d0.remy = hy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0]      <= d0;
         dv_side_ff[0] <= sl;
      end
   end

   for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
      div_type dn;
      always_comb begin
         dn = dv_ff[g];
         for (int i = 0; i < DV_BITS; i++) begin
            dn.remx = {dn.remx[64:0], dn.numx[QW - 1 - g * DV_BITS - i]};
            dn.remy = {dn.remy[64:0], dn.numy[QW - 1 - g * DV_BITS - i]};
            if (dn.remx >= 66'(dn.den)) begin
               dn.remx = dn.remx - 66'(dn.den);
               dn.qx   = {dn.qx[QW-2:0], 1'b1};
            end else dn.qx = {dn.qx[QW-2:0], 1'b0};
            if (dn.remy >= 66'(dn.den)) begin
               dn.remy = dn.remy - 66'(dn.den);
               dn.qy   = {dn.qy[QW-2:0], 1'b1};
            end else dn.qy = {dn.qy[QW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[g+1]      <= dn;
            dv_side_ff[g+1] <= dv_side_ff[g];
         end
      end
   end

   // final: cap, sign, sum, saturate
   div_type  df;
   side_type sf;
   logic [QW-1:0] qx, qy;
   logic signed [36:0] tx, ty, sx, sy;
   logic signed [65:0] sz;
   logic signed [31:0] ox, oy, oz;
   logic cx, cy, cz;
   assign df = dv_ff[DV_STAGES];
   assign sf = dv_side_ff[DV_STAGES];
   assign qx = (df.ovx || df.qx > CAP) ? CAP : df.qx;
   assign qy = (df.ovy || df.qy > CAP) ? CAP : df.qy;
   assign tx = sf.nx[63] ? -37'(qx) : 37'(qx);
   assign ty = sf.ny[63] ? -37'(qy) : 37'(qy);
   assign sx = 37'(sf.ax) + tx;
   assign sy = 37'(sf.ay) + ty;
   assign sz = 66'(sf.az) + 66'(sf.tz);

   always_comb begin
      cx = (sx > 37'sd2147483647) || (sx < -37'sd2147483648);
      ox = (sx > 37'sd2147483647) ? 32'sh7fffffff :
           (sx < -37'sd2147483648) ? 32'sh80000000 : sx[31:0];
      cy = (sy > 37'sd2147483647) || (sy < -37'sd2147483648);
      oy = (sy > 37'sd2147483647) ? 32'sh7fffffff :
           (sy < -37'sd2147483648) ? 32'sh80000000 : sy[31:0];
      cz = 1'b0;
      oz = sf.az;
      if (sf.kz) begin
         cz = (sz > 66'sd2147483647) || (sz < -66'sd2147483648);
         oz = (sz > 66'sd2147483647) ? 32'sh7fffffff :
              (sz < -66'sd2147483648) ? 32'sh80000000 : sz[31:0];
      end
   end

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.out_x   <= ox;
         out_ff.out_y   <= oy;
         out_ff.out_z   <= oz;
         out_ff.clipped <= cx || cy || cz;
      end
   end
   assign rsp.data = out_ff;

   logic unused_ok;
   assign unused_ok = ^{df.remx, df.remy, df.numx, df.numy, df.den,
                        rad[SQ_STAGES], rm[SQ_STAGES]};

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty output");
   a_in_stall: assert property (@(posedge clock) disable iff (reset)
      req.valid && !req.ready |-> rsp.valid && !rsp.ready)
      else $error("input blocked without an output stall");
`endif
endmodule
`default_nettype wire

FILE: hdl/fcv_sqrt_stage.sv
// ============================================================================
// fcv_sqrt_stage
// One registered stage of a restoring square root: resolves BITS result
// bits per stage with a remainder, advancing only when enabled.
// ============================================================================
`default_nettype none
module fcv_sqrt_stage #(
   parameter int RW   = 64,
   parameter int BITS = 4
) (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [2*RW-1:0] rad_in,
   input  wire logic [RW-1:0]   root_in,
   input  wire logic [2*RW+1:0] rem_in,
   output logic      [2*RW-1:0] rad_out,
   output logic      [RW-1:0]   root_out,
   output logic      [2*RW+1:0] rem_out
);
   logic [RW-1:0]   root_c;
   logic [2*RW+1:0] rem_c;
   logic [2*RW-1:0] rad_c;
   logic [2*RW+1:0] trial;

   // resolve BITS digits, two radicand bits each
   always_comb begin
      root_c = root_in;
      rem_c  = rem_in;
      rad_c  = rad_in;
      trial  = '0;
      for (int i = 0; i < BITS; i++) begin
         rem_c = {rem_c[2*RW-1:0], rad_c[2*RW-1 -: 2]};
         rad_c = {rad_c[2*RW-3:0], 2'b00};
         trial = {root_c, 2'b01};
         if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[RW-2:0], 1'b1};
         end else begin
            root_c = {root_c[RW-2:0], 1'b0};
         end
      end
   end

   // hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         rad_out  <= rad_c;
         root_out <= root_c;
         rem_out  <= rem_c;
      end
   end
endmodule
`default_nettype wire
